### src/ttl_pkg.sv
// ============================================================================
// ttl_pkg: shared types and constants for the thermistor table linearizer
// Holds the calibration curve, field widths and the request records that
// travel between the front end, the mid queue and the divider back end.
// ============================================================================
`default_nettype none

package ttl_pkg;

    localparam int TABLE_SLOTS  = 32;
    localparam int IDX_W        = $clog2(TABLE_SLOTS);
    localparam int PT_W         = 11;
    localparam int NUM_W        = 15;
    localparam int QUO_W        = 6;
    localparam int DIV_W        = PT_W + QUO_W;
    localparam int TEMP_W       = 8;
    localparam int STEP_DEGREES = 10;

    typedef logic [PT_W-1:0]   point_t;
    typedef logic [TEMP_W-1:0] temp_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        point_t           den;
        temp_t            base;
        logic             no_frac;
    } seg_req_t;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        point_t           den;
        logic [QUO_W-1:0] quo;
        temp_t            base;
        logic             no_frac;
    } div_state_t;

    function automatic point_t curve_adc(input logic [IDX_W-1:0] idx);
        case (idx)
            5'd0:    return 11'd35;
            5'd1:    return 11'd46;
            5'd2:    return 11'd60;
            5'd3:    return 11'd79;
            5'd4:    return 11'd107;
            5'd5:    return 11'd145;
            5'd6:    return 11'd194;
            5'd7:    return 11'd270;
            5'd8:    return 11'd369;
            5'd9:    return 11'd500;
            5'd10:   return 11'd661;
            5'd11:   return 11'd849;
            5'd12:   return 11'd1041;
            default: return '0;
        endcase
    endfunction

endpackage

`default_nettype wire

### src/ttl_queue.sv
// ============================================================================
// ttl_queue: small first-in first-out buffer
// Register-based queue with full and empty flags, used between the front end
// and the divider and again in front of the result port.
// ============================================================================
`default_nettype none

module ttl_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

### src/ttl_front.sv
// ============================================================================
// ttl_front: segment classifier
// Accepts a reading, finds the first curve point above it and registers the
// segment's base temperature, scaled numerator and segment width.
// ============================================================================
`default_nettype none

module ttl_front
    import ttl_pkg::*;
#(
    parameter int ADC_BITS     = 10,
    parameter int CURVE_POINTS = 13
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [ADC_BITS-1:0] adc_reading,
    input  wire logic                q_full,
    output logic                     q_push,
    output seg_req_t                 q_data
);

    localparam int CMP_W = (ADC_BITS > PT_W) ? ADC_BITS : PT_W;

    logic             valid_reg, valid_next;
    seg_req_t         data_reg;
    seg_req_t         seg;
    logic             advance;
    logic             hit;
    logic [CMP_W-1:0] rd_ext;
    logic [CMP_W-1:0] hi_ext;
    point_t           sel_hi, sel_lo, diff;
    temp_t            sel_base;

    assign advance = !valid_reg || !q_full;
    assign full    = !advance;
    assign q_push  = valid_reg && !q_full;
    assign q_data  = data_reg;

    always_comb
    begin
        rd_ext   = CMP_W'(adc_reading);
        hit      = 1'b0;
        sel_hi   = '0;
        sel_lo   = '0;
        sel_base = '0;
        for (int i = CURVE_POINTS - 1; i >= 1; i--)
        begin
            if (rd_ext < CMP_W'(curve_adc(IDX_W'(i))))
            begin
                hit      = 1'b1;
                sel_hi   = curve_adc(IDX_W'(i));
                sel_lo   = curve_adc(IDX_W'(i - 1));
                sel_base = TEMP_W'((CURVE_POINTS - 1 - i) * STEP_DEGREES);
            end
        end
        hi_ext       = CMP_W'(sel_hi);
        diff         = PT_W'(hi_ext - rd_ext);
        seg.num      = (NUM_W'(diff) << 3) + (NUM_W'(diff) << 1);
        seg.den      = sel_hi - sel_lo;
        seg.base     = sel_base;
        seg.no_frac  = !hit || (sel_hi <= sel_lo);
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = push;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && push)
        begin
            data_reg <= seg;
        end
    end

endmodule

`default_nettype wire

### src/ttl_back.sv
// ============================================================================
// ttl_back: pipelined segment divider
// Restoring division with one quotient bit per stage, then adds the segment
// base to form the temperature. The whole pipe holds when the result queue
// cannot take its last stage.
// ============================================================================
`default_nettype none

module ttl_back
    import ttl_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     q_empty,
    input  wire seg_req_t q_data,
    output logic          q_pop,
    input  wire logic     out_full,
    output logic          out_push,
    output temp_t         out_data
);

    localparam int STAGES = QUO_W;

    div_state_t        stage_reg [STAGES];
    div_state_t        stage_out [STAGES];
    logic [STAGES-1:0] valid_reg, valid_next;
    div_state_t        cur;
    div_state_t        last;
    logic [DIV_W-1:0]  dsh;
    logic              advance;

    assign advance  = !(valid_reg[STAGES-1] && out_full);
    assign q_pop    = advance && !q_empty;
    assign out_push = valid_reg[STAGES-1] && !out_full;
    assign last     = stage_reg[STAGES-1];
    assign out_data = last.base + (last.no_frac ? '0 : TEMP_W'(last.quo));

    always_comb
    begin
        cur = '0;
        dsh = '0;
        for (int k = 0; k < STAGES; k++)
        begin
            if (k == 0)
            begin
                cur.rem     = q_data.num;
                cur.den     = q_data.den;
                cur.quo     = '0;
                cur.base    = q_data.base;
                cur.no_frac = q_data.no_frac;
            end
            else
            begin
                cur = stage_reg[k-1];
            end
            dsh          = DIV_W'(cur.den) << (STAGES - 1 - k);
            stage_out[k] = cur;
            if (DIV_W'(cur.rem) >= dsh)
            begin
                stage_out[k].rem                   = NUM_W'(DIV_W'(cur.rem) - dsh);
                stage_out[k].quo[STAGES - 1 - k]   = 1'b1;
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = {valid_reg[STAGES-2:0], q_pop};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                stage_reg[k] <= stage_out[k];
            end
        end
    end

endmodule

`default_nettype wire

### src/thermistor_table_linearizer_top.sv
// ============================================================================
// thermistor_table_linearizer_top: coolant thermistor ADC to degrees Celsius
// Piecewise linear interpolation over a fixed calibration curve, built as a
// classifier, a request queue, a pipelined divider and a result queue.
// ============================================================================
// Path: an accepted request is registered in the classifier, passes the mid
// queue and the six-stage divider pipeline, and is written to the result queue.
// Throughput: one request per cycle, sustained while results are popped.
// Reset: rst_n clears all queues and pipeline valid flags; empty is high and
// full is low after reset.
`default_nettype none

module thermistor_table_linearizer_top
    import ttl_pkg::*;
#(
    parameter int ADC_BITS     = 10,
    parameter int CURVE_POINTS = 13,
    parameter int MID_DEPTH    = 4,
    parameter int OUT_DEPTH    = 4
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [ADC_BITS-1:0] adc_reading,
    output logic                     empty,
    input  wire logic                pop,
    output logic [TEMP_W-1:0]        temperature_c
);

    seg_req_t front_data;
    seg_req_t mid_data;
    logic     front_push;
    logic     mid_full, mid_empty, mid_pop;
    logic     res_full, res_push;
    temp_t    res_data;

    ttl_front #(
        .ADC_BITS     (ADC_BITS),
        .CURVE_POINTS (CURVE_POINTS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .adc_reading (adc_reading),
        .q_full      (mid_full),
        .q_push      (front_push),
        .q_data      (front_data)
    );

    ttl_queue #(
        .WIDTH ($bits(seg_req_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_push),
        .wr_data (front_data),
        .full    (mid_full),
        .rd_en   (mid_pop),
        .rd_data (mid_data),
        .empty   (mid_empty)
    );

    ttl_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (mid_empty),
        .q_data   (mid_data),
        .q_pop    (mid_pop),
        .out_full (res_full),
        .out_push (res_push),
        .out_data (res_data)
    );

    ttl_queue #(
        .WIDTH (TEMP_W),
        .DEPTH (OUT_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_data),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (temperature_c),
        .empty   (empty)
    );

endmodule

`default_nettype wire

### src/ttl_checker.sv
// ============================================================================
// ttl_checker: port-level checks for the thermistor table linearizer
// Tracks requests in flight and checks result holding, idle flags and the
// output range of the default curve.
// ============================================================================
`default_nettype none

module ttl_checker
    import ttl_pkg::*;
#(
    parameter int CURVE_POINTS = 13
) (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              push,
    input wire logic              full,
    input wire logic              empty,
    input wire logic              pop,
    input wire logic [TEMP_W-1:0] temperature_c
);

    logic [7:0] pending_reg, pending_next;
    logic       in_acc, out_acc;

    assign in_acc  = push && !full;
    assign out_acc = pop && !empty;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && !out_acc)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(temperature_c)))
        else $error("Waiting result changed or vanished before it was popped.");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg == 8'd0) |-> empty)
        else $error("A result is shown with no request in flight.");

    a_idle_room: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg == 8'd0) |-> !full)
        else $error("Full is raised with no request in flight.");

    a_default_range: assert property (@(posedge clk) disable iff (!rst_n)
        (CURVE_POINTS == 13 && !empty) |-> (temperature_c <= 8'd151))
        else $error("Temperature is above the range of the default curve.");

endmodule

bind thermistor_table_linearizer_top ttl_checker #(
    .CURVE_POINTS (CURVE_POINTS)
) u_ttl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .temperature_c (temperature_c)
);

`default_nettype wire
